/* hdl/run_insertion_merge_sorter_assert.svh */
// Assertion macros used by the checker file of the sorter.
`ifndef RUN_INSERTION_MERGE_SORTER_ASSERT_SVH
`define RUN_INSERTION_MERGE_SORTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RIMS_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("run_insertion_merge_sorter: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RIMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("run_insertion_merge_sorter: next-cycle check failed");

`endif

/* hdl/rims_pkg.sv */
package rims_pkg;

   localparam int KEY_W              = 32;
   localparam int CAPACITY_DEFAULT   = 64;
   localparam int RUN_SIZE_DEFAULT   = 8;

   typedef logic signed [KEY_W-1:0] key_type;

   // Source of the data written into the key memories.
   typedef enum logic [1:0] {
      WSEL_KEY,
      WSEL_V,
      WSEL_RDA,
      WSEL_MERGE
   } wsel_type;

   typedef struct packed {
      logic     bank;          // bank that holds the current sequence
      logic     wr_en;
      logic     wr_other;      // write into the bank opposite to bank
      wsel_type wsel;
      logic     v_load;        // capture port A read data as insertion key
      logic     a_live;        // first merge run still has keys
      logic     b_live;        // second merge run still has keys
      logic     out_load;
      logic     out_end;
      logic     out_overflow;
   } cmd_type;

   typedef struct packed {
      logic take_a;
      logic rda_before_v;
   } status_type;

   // True when key x may stand before key y in the selected order.
   function automatic logic key_before(input logic ascending, input key_type x,
                                       input key_type y);
      if (ascending) begin
         return x <= y;
      end
      return x >= y;
   endfunction

endpackage

/* hdl/run_insertion_merge_sorter.sv */
// Batch sorter for signed 32-bit keys: insertion-sorted runs, then bottom-up merging.
// Input: a transaction is taken at a clock edge with start high and busy low. Each
// transaction carries one key in req_key; req_last high marks the final key of the batch.
// Keys beyond CAPACITY are dropped and every result of that batch shows rsp_overflow.
// Loading takes one cycle per key; busy stays low until the final key is taken.
// Sorting then runs with busy high: each key of a run is read into the insertion
// key register, and each key ahead of it that must move is shifted up by one
// position before the key is written in place; each merge pass reads both runs
// of every pair and writes the merged keys into the other bank; the emission reads
// each key and then shows it. All of it is set by the registered read ports of the
// key memories, and the sorting time depends on how far the input is out of order.
// Output: each sorted key is shown for one cycle with rsp_valid high; the results
// are paced by memory reads and the last carries rsp_end_of_batch. The receiver
// cannot stall the block, so results must be taken when shown. busy drops as the
// last result is shown, so the next batch may start in that cycle.
// Configuration: csr_we with csr_wdata writes the order bit (1 ascending, 0
// descending); write it only while the block is idle.
// Reset (synchronous, active high) empties the batch and selects ascending order.
module run_insertion_merge_sorter #(
   parameter int CAPACITY = rims_pkg::CAPACITY_DEFAULT,
   parameter int RUN_SIZE = rims_pkg::RUN_SIZE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rims_pkg::key_type req_key,
   input  logic              req_last,
   output logic              rsp_valid,
   output rims_pkg::key_type rsp_sorted_key,
   output logic              rsp_end_of_batch,
   output logic              rsp_overflow,
   input  logic              csr_we,
   input  logic              csr_wdata
);
   import rims_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   cmd_type       cmd;
   status_type    status;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr_a;
   logic [AW-1:0] rd_addr_b;

   // The controller sequences loading, run insertion, the merge passes and the
   // emission; it owns every index and count of the batch.
   rims_controller #(
      .CAPACITY (CAPACITY),
      .RUN_SIZE (RUN_SIZE)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_last  (req_last),
      .busy      (busy),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .status    (status)
   );

   // The datapath holds the two key banks (merges ping-pong between them), the
   // insertion key register, the order comparator and the result registers.
   rims_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_key          (req_key),
      .cmd              (cmd),
      .wr_addr          (wr_addr),
      .rd_addr_a        (rd_addr_a),
      .rd_addr_b        (rd_addr_b),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_key   (rsp_sorted_key),
      .rsp_end_of_batch (rsp_end_of_batch),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

/* hdl/rims_datapath.sv */
module rims_datapath #(
   parameter int CAPACITY = rims_pkg::CAPACITY_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic                        csr_wdata,
   input  rims_pkg::key_type           req_key,
   input  rims_pkg::cmd_type           cmd,
   input  logic [$clog2(CAPACITY)-1:0] wr_addr,
   input  logic [$clog2(CAPACITY)-1:0] rd_addr_a,
   input  logic [$clog2(CAPACITY)-1:0] rd_addr_b,
   output rims_pkg::status_type        status,
   output logic                        rsp_valid,
   output rims_pkg::key_type           rsp_sorted_key,
   output logic                        rsp_end_of_batch,
   output logic                        rsp_overflow
);
   import rims_pkg::*;

   localparam int AW    = $clog2(CAPACITY);
   localparam int DEPTH = 1 << AW;

   key_type  bank0_mem [DEPTH];
   key_type  bank1_mem [DEPTH];
   key_type  b0_rda_ff, b0_rdb_ff, b1_rda_ff, b1_rdb_ff;
   logic     bank_ff;
   key_type  rda, rdb;
   key_type  v_ff;
   key_type  wr_data;
   logic     wr_bank;
   logic     ascending_ff;
   logic     take_a;
   logic     rsp_valid_ff, rsp_end_ff, rsp_overflow_ff;
   key_type  rsp_key_ff;

   assign wr_bank = cmd.bank ^ cmd.wr_other;

   always_ff @(posedge clock) begin
      if (cmd.wr_en && !wr_bank) begin
         bank0_mem[wr_addr] <= wr_data;
      end
      b0_rda_ff <= bank0_mem[rd_addr_a];
      b0_rdb_ff <= bank0_mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_bank) begin
         bank1_mem[wr_addr] <= wr_data;
      end
      b1_rda_ff <= bank1_mem[rd_addr_a];
      b1_rdb_ff <= bank1_mem[rd_addr_b];
   end

   // Read data follows the bank that was addressed in the previous cycle.
   always_ff @(posedge clock) begin
      bank_ff <= cmd.bank;
      if (cmd.v_load) begin
         v_ff <= rda;
      end
   end

   assign rda = bank_ff ? b1_rda_ff : b0_rda_ff;
   assign rdb = bank_ff ? b1_rdb_ff : b0_rdb_ff;

   assign take_a = cmd.a_live && (!cmd.b_live || key_before(ascending_ff, rda, rdb));

   always_comb begin
      unique case (cmd.wsel)
         WSEL_KEY:   wr_data = req_key;
         WSEL_V:     wr_data = v_ff;
         WSEL_RDA:   wr_data = rda;
         WSEL_MERGE: wr_data = take_a ? rda : rdb;
         default:    wr_data = req_key;
      endcase
   end

   assign status.take_a       = take_a;
   assign status.rda_before_v = key_before(ascending_ff, rda, v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ascending_ff <= 1'b1;
      end else if (csr_we) begin
         ascending_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         rsp_end_ff      <= 1'b0;
         rsp_overflow_ff <= 1'b0;
      end else begin
         rsp_valid_ff    <= cmd.out_load;
         rsp_end_ff      <= cmd.out_load & cmd.out_end;
         rsp_overflow_ff <= cmd.out_load & cmd.out_overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_key_ff <= rda;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_key   = rsp_key_ff;
   assign rsp_end_of_batch = rsp_end_ff;
   assign rsp_overflow     = rsp_overflow_ff;

endmodule

/* hdl/rims_controller.sv */
module rims_controller #(
   parameter int CAPACITY = rims_pkg::CAPACITY_DEFAULT,
   parameter int RUN_SIZE = rims_pkg::RUN_SIZE_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        req_last,
   output logic                        busy,
   output rims_pkg::cmd_type           cmd,
   output logic [$clog2(CAPACITY)-1:0] wr_addr,
   output logic [$clog2(CAPACITY)-1:0] rd_addr_a,
   output logic [$clog2(CAPACITY)-1:0] rd_addr_b,
   input  rims_pkg::status_type        status
);
   import rims_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = $clog2(3 * CAPACITY + RUN_SIZE + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [XW-1:0] RUN_C = XW'(RUN_SIZE);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_NEXT,
      ST_INS_LOADV,
      ST_INS_PROBE,
      ST_INS_CMP,
      ST_MRG_PASS,
      ST_MRG_SEG,
      ST_MRG_RD,
      ST_MRG_CMP,
      ST_OUT_RD,
      ST_OUT_WR
   } state_type;

   state_type     state_ff, state_in;
   logic          busy_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] n_ff, n_in;
   logic          dropped_ff, dropped_in;
   logic          src_ff, src_in;
   logic [XW-1:0] lo_ff, lo_in;
   logic [XW-1:0] width_ff, width_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] a_ff, a_in;
   logic [CW-1:0] b_ff, b_in;
   logic [CW-1:0] k_ff, k_in;

   logic          stored;
   logic [XW-1:0] n_x;
   logic [XW-1:0] lo_run;
   logic [XW-1:0] lo_pair;
   logic [CW-1:0] jm1;
   logic [CW-1:0] kp1;

   // Smaller of x and lim; lim never exceeds the capacity.
   function automatic logic [CW-1:0] clip(input logic [XW-1:0] x, input logic [XW-1:0] lim);
      if (x < lim) begin
         return CW'(x);
      end
      return CW'(lim);
   endfunction

   assign stored  = count_ff < CAP_C;
   assign n_x     = XW'(n_ff);
   assign lo_run  = lo_ff + RUN_C;
   assign lo_pair = lo_ff + (width_ff << 1);
   assign jm1     = j_ff - CW'(1);
   assign kp1     = k_ff + CW'(1);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      n_in       = n_ff;
      dropped_in = dropped_ff;
      src_in     = src_ff;
      lo_in      = lo_ff;
      width_in   = width_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      k_in       = k_ff;
      cmd        = '0;
      cmd.bank   = src_ff;
      cmd.wsel   = WSEL_KEY;
      wr_addr    = '0;
      rd_addr_a  = '0;
      rd_addr_b  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            wr_addr = count_ff[AW-1:0];
            if (start) begin
               cmd.wr_en  = stored;
               count_in   = count_ff + CW'(stored);
               dropped_in = dropped_ff | !stored;
               if (req_last) begin
                  n_in     = count_in;
                  src_in   = 1'b0;
                  lo_in    = '0;
                  i_in     = CW'(1);
                  hi_in    = clip(RUN_C, XW'(count_in));
                  state_in = ST_INS_NEXT;
               end
            end
         end

         ST_INS_NEXT: begin
            rd_addr_a = i_ff[AW-1:0];
            if (i_ff < hi_ff) begin
               j_in     = i_ff;
               state_in = ST_INS_LOADV;
            end else if (lo_run < n_x) begin
               lo_in = lo_run;
               i_in  = CW'(lo_run + XW'(1));
               hi_in = clip(lo_run + RUN_C, n_x);
            end else begin
               width_in = RUN_C;
               state_in = ST_MRG_PASS;
            end
         end

         ST_INS_LOADV: begin
            cmd.v_load = 1'b1;
            state_in   = ST_INS_PROBE;
         end

         ST_INS_PROBE: begin
            rd_addr_a = jm1[AW-1:0];
            wr_addr   = j_ff[AW-1:0];
            if (XW'(j_ff) > lo_ff) begin
               state_in = ST_INS_CMP;
            end else begin
               cmd.wr_en = 1'b1;
               cmd.wsel  = WSEL_V;
               i_in      = i_ff + CW'(1);
               state_in  = ST_INS_NEXT;
            end
         end

         ST_INS_CMP: begin
            wr_addr   = j_ff[AW-1:0];
            cmd.wr_en = 1'b1;
            if (!status.rda_before_v) begin
               cmd.wsel = WSEL_RDA;
               j_in     = jm1;
               state_in = ST_INS_PROBE;
            end else begin
               cmd.wsel = WSEL_V;
               i_in     = i_ff + CW'(1);
               state_in = ST_INS_NEXT;
            end
         end

         ST_MRG_PASS: begin
            if (width_ff < n_x) begin
               lo_in    = '0;
               state_in = ST_MRG_SEG;
            end else begin
               k_in     = '0;
               state_in = ST_OUT_RD;
            end
         end

         ST_MRG_SEG: begin
            if (lo_ff < n_x) begin
               mid_in   = clip(lo_ff + width_ff, n_x);
               hi_in    = clip(lo_pair, n_x);
               a_in     = CW'(lo_ff);
               b_in     = mid_in;
               k_in     = CW'(lo_ff);
               state_in = ST_MRG_RD;
            end else begin
               src_in   = ~src_ff;
               width_in = width_ff << 1;
               state_in = ST_MRG_PASS;
            end
         end

         ST_MRG_RD: begin
            rd_addr_a = a_ff[AW-1:0];
            rd_addr_b = b_ff[AW-1:0];
            if (k_ff < hi_ff) begin
               state_in = ST_MRG_CMP;
            end else begin
               lo_in    = lo_pair;
               state_in = ST_MRG_SEG;
            end
         end

         ST_MRG_CMP: begin
            cmd.a_live   = a_ff < mid_ff;
            cmd.b_live   = b_ff < hi_ff;
            cmd.wr_en    = 1'b1;
            cmd.wr_other = 1'b1;
            cmd.wsel     = WSEL_MERGE;
            wr_addr      = k_ff[AW-1:0];
            k_in         = kp1;
            if (status.take_a) begin
               a_in = a_ff + CW'(1);
            end else begin
               b_in = b_ff + CW'(1);
            end
            state_in = ST_MRG_RD;
         end

         ST_OUT_RD: begin
            rd_addr_a = k_ff[AW-1:0];
            state_in  = ST_OUT_WR;
         end

         ST_OUT_WR: begin
            cmd.out_load     = 1'b1;
            cmd.out_overflow = dropped_ff;
            cmd.out_end      = kp1 == n_ff;
            if (kp1 == n_ff) begin
               count_in   = '0;
               dropped_in = 1'b0;
               src_in     = 1'b0;
               state_in   = ST_IDLE;
            end else begin
               k_in     = kp1;
               state_in = ST_OUT_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         busy_ff    <= 1'b0;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         src_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         busy_ff    <= state_in != ST_IDLE;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         src_ff     <= src_in;
      end
      n_ff     <= n_in;
      lo_ff    <= lo_in;
      width_ff <= width_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      k_ff     <= k_in;
   end

   assign busy = busy_ff;

endmodule

/* hdl/rims_checker.sv */
`include "run_insertion_merge_sorter_assert.svh"

module rims_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_end_of_batch,
   input logic rsp_overflow
);

   // The final key of a batch always starts a sort.
   `RIMS_ASSERT_NEXT(a_last_starts_sort, clock, reset, start && !busy && req_last, busy)

   // Results of one batch are spaced by the memory read.
   `RIMS_ASSERT_NEXT(a_strobe_spacing, clock, reset, rsp_valid, !rsp_valid)

   // More results are due, so the block stays busy.
   `RIMS_ASSERT_HOLDS(a_busy_mid_batch, clock, reset, rsp_valid && !rsp_end_of_batch, busy)

   // The block is free again as the final result is shown.
   `RIMS_ASSERT_HOLDS(a_free_at_end, clock, reset, rsp_valid && rsp_end_of_batch, !busy)

   // Batch flags appear only with a result.
   `RIMS_ASSERT_HOLDS(a_flags_with_strobe, clock, reset, !rsp_valid,
                      !rsp_end_of_batch && !rsp_overflow)

endmodule

bind run_insertion_merge_sorter rims_checker u_checker (.*);

/* bench/run_insertion_merge_sorter_tb.sv */
module run_insertion_merge_sorter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rims_pkg::*;

   // The block is built with its default sizes, and the predictor uses the same ones.
   localparam int CAPACITY     = CAPACITY_DEFAULT;
   localparam int RUN_SIZE     = RUN_SIZE_DEFAULT;
   // The slowest correct run is well under a tenth of this. Each key costs its
   // sorting work plus at most a long sender gap, over a few hundred keys.
   localparam int LIMIT_CYCLES = 400000;
   // These cycles follow the last result before the block counts as idle. They cover
   // busy dropping and anything the block might still be doing after a batch.
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_ITEMS = 40;
   localparam int MAX_REPORTS  = 10;

   localparam key_type KEY_MIN = 32'h8000_0000;
   localparam key_type KEY_MAX = 32'h7FFF_FFFF;

   // This is one sorted key as the block should present it.
   typedef struct {
      key_type key;
      logic    end_of_batch;
      logic    overflow;
   } sorted_item_type;

   // Every input is driven to a known value from time zero. Reset starts asserted.
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   key_type req_key   = '0;
   logic    req_last  = 1'b0;
   logic    csr_we    = 1'b0;
   logic    csr_wdata = 1'b0;

   logic    busy;
   logic    rsp_valid;
   key_type rsp_sorted_key;
   logic    rsp_end_of_batch;
   logic    rsp_overflow;

   // This is the predictor's own copy of the sort order, the open batch and the drop flag.
   logic            order_ascending = 1'b1;
   key_type         held_keys[$];
   logic            keys_dropped    = 1'b0;
   // These sorted results have been worked out and wait for the block to send them.
   sorted_item_type pending_sorted[$];

   int fail_count   = 0;
   int cycle_count  = 0;
   int keys_sent    = 0;
   // When this is clear, the sender presents keys back to back with no gaps.
   bit idle_gaps    = 1'b1;

   key_type extreme_keys[11] = '{KEY_MAX, KEY_MIN, 32'sd0, -32'sd1, 32'sd1,
                                 32'h5555_5555, 32'hAAAA_AAAA, KEY_MAX, KEY_MIN,
                                 32'sd3, 32'sd3};

   run_insertion_merge_sorter #(
      .CAPACITY(CAPACITY),
      .RUN_SIZE(RUN_SIZE)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_key         (req_key),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_sorted_key  (rsp_sorted_key),
      .rsp_end_of_batch(rsp_end_of_batch),
      .rsp_overflow    (rsp_overflow),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // This is true when key a may stand ahead of key b in the current order. Equal
   // keys can go either way, because equal keys cannot be told apart.
   function automatic logic ranks_first(input key_type a, input key_type b);
      if (order_ascending) begin
         return a <= b;
      end
      return a >= b;
   endfunction

   // This sorts the keys held in the batch. Each key goes in after the last entry
   // that may stand ahead of it. Then one result per key is queued with its flags,
   // and the batch state is cleared for the next batch.
   function automatic void predict_sorted_batch();
      key_type         ordered[$];
      sorted_item_type item;
      int              pos;
      foreach (held_keys[i]) begin
         pos = 0;
         while (pos < ordered.size() && ranks_first(ordered[pos], held_keys[i])) begin
            pos++;
         end
         ordered.insert(pos, held_keys[i]);
      end
      foreach (ordered[i]) begin
         item.key          = ordered[i];
         item.end_of_batch = (i == ordered.size() - 1);
         item.overflow     = keys_dropped;
         pending_sorted.push_back(item);
      end
      held_keys.delete();
      keys_dropped = 1'b0;
   endfunction

   // This updates the predictor for one accepted transaction. A key that arrives while
   // the store is full is dropped. The last key still starts the sort even if it is
   // dropped itself.
   function automatic void take_key(input key_type k, input logic last);
      if (held_keys.size() < CAPACITY) begin
         held_keys.push_back(k);
      end else begin
         keys_dropped = 1'b1;
      end
      if (last) begin
         predict_sorted_batch();
      end
   endfunction

   // Most gaps are zero or short and a few are long. They are zero while gaps are off.
   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_gaps || r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // This mixes full-range keys with extremes and a narrow band near zero. The
   // narrow band gives many equal keys in a batch.
   function automatic key_type random_key();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return KEY_MIN;
               1: return KEY_MAX;
               2: return '0;
               default: return -32'sd1;
            endcase
         end
         1, 2: return key_type'($urandom_range(0, 8)) - 32'sd4;
         default: return key_type'($urandom());
      endcase
   endfunction

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("[%0t] %s", $realtime, what);
      end
   endfunction

   // This sends one transaction. The task is entered just after a rising edge. After an
   // optional gap with start low, it holds the key until an edge finds busy low. It
   // returns at that edge, so start stays high if the next key follows at once.
   task automatic send_key(input key_type k, input logic last, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_key  <= k;
      req_last <= last;
      do @(posedge clock); while (busy);
      take_key(k, last);
      keys_sent++;
   endtask

   task automatic send_random_batch(input int n);
      for (int i = 0; i < n; i++) begin
         send_key(random_key(), i == n - 1, rand_gap());
      end
   endtask

   // This lowers start and waits until every predicted result has come and busy is
   // low. The extra drain cycles then catch any stray result.
   task automatic wait_for_results();
      start    <= 1'b0;
      req_last <= 1'b0;
      while (pending_sorted.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The order register is written only while the block is idle. The task lowers
   // csr_we after the write edge and waits for another edge before it returns.
   // Two writes in a row therefore never drive csr_we twice in one time step.
   task automatic write_order(input logic ascending);
      csr_we    <= 1'b1;
      csr_wdata <= ascending;
      @(posedge clock);
      order_ascending = ascending;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // This tests the extremes of the key range in ascending order, using the order
   // set by reset. The batch holds duplicates, the most negative and the most positive
   // key, and a single-key batch whose only result is also the last one.
   task automatic test_extreme_keys_ascending();
      foreach (extreme_keys[i]) begin
         send_key(extreme_keys[i], i == $size(extreme_keys) - 1, 0);
      end
      send_key(-32'sd7, 1'b1, 2);
      wait_for_results();
   endtask

   // This is the same kind of batch sorted largest first, then a single-key batch at
   // the most negative key. Ascending order is written back at the end.
   task automatic test_extreme_keys_descending();
      write_order(1'b0);
      for (int i = 0; i < 9; i++) begin
         send_key(extreme_keys[i], i == 8, i % 3);
      end
      send_key(KEY_MIN, 1'b1, 0);
      wait_for_results();
      write_order(1'b1);
   endtask

   // This tests the store limits. A batch of exactly CAPACITY keys fills the store
   // with no overflow. A longer batch drops the keys past the limit, the last key
   // among them, and must flag overflow on every result.
   task automatic test_capacity_overflow();
      send_random_batch(CAPACITY);
      wait_for_results();
      write_order(1'b0);
      send_random_batch(CAPACITY + 3);
      wait_for_results();
   endtask

   // This sends random batches until about RANDOM_ITEMS keys have gone in. Most
   // batches are short. Some sit on run-size boundaries, where a tail run gets no
   // merge partner, and a few are close to full. Between some batches the sender waits
   // for all results and may flip the order. Otherwise the next batch presses on the
   // block while it is still sorting.
   task automatic test_random_batches();
      int first_key;
      int n;
      int r;
      first_key = keys_sent;
      while (keys_sent - first_key < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            n = $urandom_range(1, 20);
         end else if (r < 92) begin
            n = RUN_SIZE * $urandom_range(1, 4) + $urandom_range(0, 2) - 1;
         end else begin
            n = $urandom_range(40, CAPACITY);
         end
         idle_gaps = ($urandom_range(0, 2) != 0);
         send_random_batch(n);
         if ($urandom_range(0, 2) == 0) begin
            wait_for_results();
            write_order($urandom_range(0, 1));
         end
      end
      idle_gaps = 1'b1;
   endtask

   // Results are taken at the edge that ends their strobe cycle. Each one is compared
   // field by field with the oldest prediction.
   always @(posedge clock) begin : check_results
      sorted_item_type want;
      if (!reset && rsp_valid) begin
         if (pending_sorted.size() == 0) begin
            note_failure($sformatf("unexpected result: key %0d end %0b overflow %0b",
                                   rsp_sorted_key, rsp_end_of_batch, rsp_overflow));
         end else begin
            want = pending_sorted.pop_front();
            if (rsp_sorted_key !== want.key || rsp_end_of_batch !== want.end_of_batch ||
                rsp_overflow !== want.overflow) begin
               note_failure($sformatf({"result mismatch: expected key %0d end %0b ",
                                       "overflow %0b, got key %0d end %0b overflow %0b"},
                                      want.key, want.end_of_batch, want.overflow,
                                      rsp_sorted_key, rsp_end_of_batch, rsp_overflow));
            end
         end
      end
   end

   // The watchdog ends a run that hangs. It counts clock cycles up to the limit.
   initial begin : watchdog
      for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) begin
         @(posedge clock);
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : run_tests
      // Reset is released at a rising edge and is never asserted again.
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extreme_keys_ascending();
      test_extreme_keys_descending();
      test_capacity_overflow();
      test_random_batches();

      // Every key has been accepted. The last call waits out the final batch and
      // the drain cycles.
      wait_for_results();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* run_insertion_merge_sorter.f */
+incdir+hdl
hdl/rims_pkg.sv
hdl/rims_datapath.sv
hdl/rims_controller.sv
hdl/run_insertion_merge_sorter.sv
hdl/rims_checker.sv
bench/run_insertion_merge_sorter_tb.sv
